// File: hdl/rotary_encoder_button_decoder_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the rotary encoder button decoder
// Concurrent checks that can be compiled out by defining ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef ROTARY_ENCODER_BUTTON_DECODER_MACROS_SVH
`define ROTARY_ENCODER_BUTTON_DECODER_MACROS_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define REB_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed in %m");

// The consequent must hold in the cycle after the antecedent.
`define REB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed in %m");

`else

`define REB_ASSERT_SAME(label, clk, rst, ante, cons)
`define REB_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: hdl/reb_pkg.sv
// ----------------------------------------------------------------------------
// Rotary encoder button decoder package
// Shared types, event codes and timing constants.
// ----------------------------------------------------------------------------
package reb_pkg;

   typedef logic [1:0]  pair_type;
   typedef logic [31:0] ms_type;

   typedef enum logic [2:0] {
      EV_NONE  = 3'd0,
      EV_CW    = 3'd1,
      EV_CCW   = 3'd2,
      EV_CLICK = 3'd3,
      EV_LONG  = 3'd4
   } event_type;

   typedef enum logic [1:0] {
      DIR_IDLE = 2'd0,
      DIR_CW   = 2'd1,
      DIR_CCW  = 2'd2
   } dir_type;

   typedef enum logic [1:0] {
      CSR_LONG_PRESS = 2'd0,
      CSR_DEBOUNCE   = 2'd1
   } csr_index_type;

   // One sample of the pins together with its time stamp.
   typedef struct packed {
      logic   clk_level;
      logic   dt_level;
      logic   sw_level;
      ms_type now_ms;
   } sample_type;

   typedef struct packed {
      ms_type long_press_ms;
      ms_type debounce_ms;
   } cfg_type;

   localparam pair_type PAIR_IDLE = 2'b11;

   // Gray sequences of the pair {A, B} for one full detent.
   localparam pair_type CW_ORDER  [4] = '{2'b01, 2'b00, 2'b10, 2'b11};
   localparam pair_type CCW_ORDER [4] = '{2'b10, 2'b00, 2'b01, 2'b11};

   localparam ms_type SEQ_TIMEOUT_MS    = 32'd100;
   localparam ms_type HOLD_GUARD_MS     = 32'd500;
   localparam ms_type COOLDOWN_MS       = 32'd1000;
   localparam ms_type COOLDOWN_CLEAR_MS = 32'd1050;

   localparam ms_type LONG_PRESS_RESET = 32'd1000;
   localparam ms_type DEBOUNCE_RESET   = 32'd200;

endpackage

// File: hdl/reb_rotation.sv
// ----------------------------------------------------------------------------
// Rotation tracker
// Follows the quadrature Gray sequence and reports one full detent per step.
// ----------------------------------------------------------------------------
module reb_rotation (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  reb_pkg::sample_type  sample,
   output reb_pkg::event_type   rot_event
);

   reb_pkg::pair_type  last_pair_ff, last_pair_in;
   logic [1:0]         seq_step_ff, seq_step_in;
   reb_pkg::dir_type   seq_dir_ff, seq_dir_in;
   reb_pkg::ms_type    seq_stamp_ff, seq_stamp_in;

   reb_pkg::pair_type  pair;
   reb_pkg::pair_type  want_pair;
   reb_pkg::ms_type    seq_age;
   logic [1:0]         step_a;
   reb_pkg::dir_type   dir_a;
   logic               pair_moved;

   assign pair       = {sample.clk_level, sample.dt_level};
   assign seq_age    = sample.now_ms - seq_stamp_ff;
   assign pair_moved = (pair != last_pair_ff) && ((pair ^ last_pair_ff) != 2'b11);

   always_comb begin
      last_pair_in = last_pair_ff;
      seq_step_in  = seq_step_ff;
      seq_dir_in   = seq_dir_ff;
      seq_stamp_in = seq_stamp_ff;
      rot_event    = reb_pkg::EV_NONE;
      step_a       = seq_step_ff;
      dir_a        = seq_dir_ff;
      want_pair    = reb_pkg::PAIR_IDLE;

      // A double-bit change is bounce and leaves the tracker untouched.
      if (pair_moved) begin
         last_pair_in = pair;
         if (seq_step_ff != 2'd0 && seq_age > reb_pkg::SEQ_TIMEOUT_MS) begin
            step_a = 2'd0;
            dir_a  = reb_pkg::DIR_IDLE;
         end
         seq_step_in = step_a;
         seq_dir_in  = dir_a;

         if (step_a == 2'd0) begin
            if (pair == reb_pkg::CW_ORDER[0]) begin
               seq_dir_in   = reb_pkg::DIR_CW;
               seq_step_in  = 2'd1;
               seq_stamp_in = sample.now_ms;
            end else if (pair == reb_pkg::CCW_ORDER[0]) begin
               seq_dir_in   = reb_pkg::DIR_CCW;
               seq_step_in  = 2'd1;
               seq_stamp_in = sample.now_ms;
            end
         end else begin
            case (dir_a)
               reb_pkg::DIR_CW: begin
                  want_pair = reb_pkg::CW_ORDER[step_a];
               end
               reb_pkg::DIR_CCW: begin
                  want_pair = reb_pkg::CCW_ORDER[step_a];
               end
               default: begin
                  want_pair = reb_pkg::PAIR_IDLE;
               end
            endcase

            if (dir_a != reb_pkg::DIR_IDLE && pair == want_pair) begin
               if (step_a == 2'd3) begin
                  seq_step_in = 2'd0;
                  seq_dir_in  = reb_pkg::DIR_IDLE;
                  rot_event   = (dir_a == reb_pkg::DIR_CW) ? reb_pkg::EV_CW
                                                            : reb_pkg::EV_CCW;
               end else begin
                  seq_step_in  = step_a + 2'd1;
                  seq_stamp_in = sample.now_ms;
               end
            end else if (pair == reb_pkg::PAIR_IDLE) begin
               seq_step_in = 2'd0;
               seq_dir_in  = reb_pkg::DIR_IDLE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_pair_ff <= reb_pkg::PAIR_IDLE;
         seq_step_ff  <= 2'd0;
         seq_dir_ff   <= reb_pkg::DIR_IDLE;
         seq_stamp_ff <= '0;
      end else if (step_en) begin
         last_pair_ff <= last_pair_in;
         seq_step_ff  <= seq_step_in;
         seq_dir_ff   <= seq_dir_in;
         seq_stamp_ff <= seq_stamp_in;
      end
   end

endmodule

// File: hdl/reb_button.sv
// ----------------------------------------------------------------------------
// Button tracker
// Debounced click on release, long press on hold, cooldown after a long press.
// ----------------------------------------------------------------------------
module reb_button (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  reb_pkg::sample_type  sample,
   input  reb_pkg::cfg_type     cfg,
   output reb_pkg::event_type   btn_event
);

   logic               last_button_ff, last_button_in;
   reb_pkg::ms_type    press_start_ff, press_start_in;
   logic               long_seen_ff, long_seen_in;
   reb_pkg::ms_type    last_action_ff, last_action_in;
   reb_pkg::ms_type    cooldown_stamp_ff, cooldown_stamp_in;

   logic               press_edge;
   logic               release_edge;
   reb_pkg::ms_type    press_a;
   logic               long_a;
   reb_pkg::ms_type    held_ms;
   reb_pkg::ms_type    since_action;
   reb_pkg::ms_type    since_cool;
   logic               cooling;
   logic               long_hit;

   assign press_edge   = last_button_ff && !sample.sw_level;
   assign release_edge = !last_button_ff && sample.sw_level;
   assign press_a      = press_edge ? sample.now_ms : press_start_ff;
   assign long_a       = press_edge ? 1'b0 : long_seen_ff;
   assign held_ms      = sample.now_ms - press_a;
   assign since_action = sample.now_ms - last_action_ff;
   assign since_cool   = sample.now_ms - cooldown_stamp_ff;
   assign cooling      = cooldown_stamp_ff != '0;

   // A press that started at time zero can never turn into a long press.
   assign long_hit = !sample.sw_level && !long_a && (press_a != '0)
                     && (held_ms >= cfg.long_press_ms)
                     && (since_action >= cfg.debounce_ms);

   always_comb begin
      last_button_in    = sample.sw_level;
      press_start_in    = press_a;
      long_seen_in      = long_a;
      last_action_in    = last_action_ff;
      cooldown_stamp_in = cooldown_stamp_ff;
      btn_event         = reb_pkg::EV_NONE;

      if (long_hit) begin
         long_seen_in      = 1'b1;
         last_action_in    = sample.now_ms;
         cooldown_stamp_in = sample.now_ms;
         btn_event         = reb_pkg::EV_LONG;
      end else if (release_edge && cooling && since_cool < reb_pkg::COOLDOWN_MS) begin
         btn_event = reb_pkg::EV_NONE;
      end else if (release_edge && !long_a && since_action >= cfg.debounce_ms) begin
         last_action_in = sample.now_ms;
         btn_event      = reb_pkg::EV_CLICK;
      end else begin
         if (release_edge && long_a && since_cool > reb_pkg::HOLD_GUARD_MS) begin
            long_seen_in = 1'b0;
         end
         if (cooling && since_cool > reb_pkg::COOLDOWN_CLEAR_MS) begin
            cooldown_stamp_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_button_ff    <= 1'b1;
         press_start_ff    <= '0;
         long_seen_ff      <= 1'b0;
         last_action_ff    <= '0;
         cooldown_stamp_ff <= '0;
      end else if (step_en) begin
         last_button_ff    <= last_button_in;
         press_start_ff    <= press_start_in;
         long_seen_ff      <= long_seen_in;
         last_action_ff    <= last_action_in;
         cooldown_stamp_ff <= cooldown_stamp_in;
      end
   end

endmodule

// File: hdl/rotary_encoder_button_decoder.sv
// ----------------------------------------------------------------------------
// Rotary encoder button decoder
// Turns pin samples of a quadrature encoder with push button into events.
// ----------------------------------------------------------------------------
// Each req transaction carries one sample: encoder levels A and B, button
// level (0 pressed) and a millisecond time stamp. Each sample yields exactly
// one rsp transaction with an event code: none, clockwise, counterclockwise,
// click or long press. Rotation is decoded first; on a sample that completes
// a detent the button is not looked at.
// The sample is held in an input register, decoded by one level of compare
// and subtract logic and written to a result register. The earliest rsp
// handshake follows the req handshake through the input and result registers,
// and one transaction per cycle is sustained while rsp_ready is high.
// When rsp_ready is low the result register holds, the input register still
// takes one more sample, and req_ready drops only once both are full.
// The csr channel is always ready; index 0 writes the long press hold time,
// index 1 the debounce time, other indexes are ignored. Write it while idle.
// Reset (synchronous) empties both registers, restores the hold time to
// 1000 ms and the debounce time to 200 ms, and returns the decoder state to
// both pins high, button released, no press and no cooldown.
// ----------------------------------------------------------------------------
`include "rotary_encoder_button_decoder_macros.svh"

module rotary_encoder_button_decoder (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic         req_clk_level,
   input  logic         req_dt_level,
   input  logic         req_sw_level,
   input  logic [31:0]  req_now_ms,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [2:0]   rsp_event_code,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   logic                 in_vld_ff, in_vld_in;
   reb_pkg::sample_type  sample_ff;
   logic                 out_vld_ff, out_vld_in;
   reb_pkg::event_type   out_event_ff;
   reb_pkg::cfg_type     cfg_ff;

   logic                 advance;
   logic                 req_take;
   reb_pkg::event_type   rot_event;
   reb_pkg::event_type   btn_event;

   assign advance   = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;
   assign req_take  = req_valid && req_ready;
   assign in_vld_in = req_take || (in_vld_ff && !advance);
   assign out_vld_in = advance || (out_vld_ff && !rsp_ready);

   assign csr_ready      = 1'b1;
   assign rsp_valid      = out_vld_ff;
   assign rsp_event_code = out_event_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         sample_ff <= '{clk_level: req_clk_level, dt_level: req_dt_level,
                        sw_level: req_sw_level, now_ms: req_now_ms};
      end
      if (advance) begin
         out_event_ff <= (rot_event != reb_pkg::EV_NONE) ? rot_event : btn_event;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_press_ms <= reb_pkg::LONG_PRESS_RESET;
         cfg_ff.debounce_ms   <= reb_pkg::DEBOUNCE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            reb_pkg::CSR_LONG_PRESS: begin
               cfg_ff.long_press_ms <= csr_wdata;
            end
            reb_pkg::CSR_DEBOUNCE: begin
               cfg_ff.debounce_ms <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   reb_rotation u_rotation (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .sample    (sample_ff),
      .rot_event (rot_event)
   );

   // The button state stands still on a sample that reports a rotation step.
   reb_button u_button (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance && (rot_event == reb_pkg::EV_NONE)),
      .sample    (sample_ff),
      .cfg       (cfg_ff),
      .btn_event (btn_event)
   );

   `REB_ASSERT_NEXT(a_advance_gives_result, clock, reset, advance, out_vld_ff)
   `REB_ASSERT_NEXT(a_take_fills_input, clock, reset, req_take, in_vld_ff)
   `REB_ASSERT_NEXT(a_waiting_sample_kept, clock, reset, in_vld_ff && !advance,
                    in_vld_ff && $stable(sample_ff))
   `REB_ASSERT_SAME(a_full_blocks_req, clock, reset, in_vld_ff && out_vld_ff && !rsp_ready,
                    !req_ready)

endmodule
